/* rtl/hsse_pkg.sv */
// Shared types, character constants and helper functions for the script span extractor.
`timescale 1ns / 1ps

package hsse_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_SRC  = 2'd0;
   localparam logic [1:0] KIND_BODY = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Characters that steer the scanner.
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_EQ     = 8'h3D;

   // Needle lengths.
   localparam logic [3:0] OPEN_LEN  = 4'd7;
   localparam logic [2:0] ATTR_LEN  = 3'd4;
   localparam logic [3:0] CLOSE_LEN = 4'd9;

   // One result item.
   typedef struct packed {
      logic [1:0]  span_kind;
      logic [31:0] span_start;
      logic [31:0] span_length;
      logic [6:0]  scripts_found;
      logic        final_of_item;
   } rsp_type;

   // Up to two results produced by one request, in order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } push_type;

   // Lower-case the letters A-Z only.
   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c inside {[8'h41:8'h5A]}) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   // Characters of "<script".
   function automatic logic [7:0] open_char(input logic [2:0] idx);
      case (idx)
         3'd0:    return CH_LT;
         3'd1:    return 8'h73;
         3'd2:    return 8'h63;
         3'd3:    return 8'h72;
         3'd4:    return 8'h69;
         3'd5:    return 8'h70;
         default: return 8'h74;
      endcase
   endfunction

   // Characters of "src=".
   function automatic logic [7:0] attr_char(input logic [1:0] idx);
      case (idx)
         2'd0:    return 8'h73;
         2'd1:    return 8'h72;
         2'd2:    return 8'h63;
         default: return CH_EQ;
      endcase
   endfunction

   // Characters of "</script>".
   function automatic logic [7:0] close_char(input logic [3:0] idx);
      case (idx)
         4'd0:    return CH_LT;
         4'd1:    return CH_SLASH;
         4'd2:    return 8'h73;
         4'd3:    return 8'h63;
         4'd4:    return 8'h72;
         4'd5:    return 8'h69;
         4'd6:    return 8'h70;
         4'd7:    return 8'h74;
         default: return CH_GT;
      endcase
   endfunction

   // Matcher step for a needle with distinct characters.
   function automatic logic [3:0] adv_open(input logic [3:0] prog, input logic [7:0] c);
      if (prog < OPEN_LEN && c == open_char(prog[2:0])) begin
         return prog + 4'd1;
      end
      return (c == CH_LT) ? 4'd1 : 4'd0;
   endfunction

   function automatic logic [2:0] adv_attr(input logic [2:0] prog, input logic [7:0] c);
      if (prog < ATTR_LEN && c == attr_char(prog[1:0])) begin
         return prog + 3'd1;
      end
      return (c == attr_char(2'd0)) ? 3'd1 : 3'd0;
   endfunction

   function automatic logic [3:0] adv_close(input logic [3:0] prog, input logic [7:0] c);
      if (prog < CLOSE_LEN && c == close_char(prog)) begin
         return prog + 4'd1;
      end
      return (c == CH_LT) ? 4'd1 : 4'd0;
   endfunction

endpackage

/* rtl/hsse_scan.sv */
// Scanner state and the per-byte step that produces span and done results.
`timescale 1ns / 1ps

module hsse_scan #(
   parameter int MAX_SCRIPTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         doc_byte,
   input  logic               doc_end,
   output hsse_pkg::push_type push
);
   import hsse_pkg::*;

   localparam logic [2:0] M_SEARCH    = 3'd0;
   localparam logic [2:0] M_TAG       = 3'd1;
   localparam logic [2:0] M_AFTER_SRC = 3'd2;
   localparam logic [2:0] M_VALUE     = 3'd3;
   localparam logic [2:0] M_TAG_REST  = 3'd4;
   localparam logic [2:0] M_BODY      = 3'd5;
   localparam logic [2:0] M_STOPPED   = 3'd6;

   localparam logic [6:0] MAX_COUNT = 7'(MAX_SCRIPTS);

   logic [31:0] offset_ff, offset_in;
   logic [2:0]  mode_ff, mode_in;
   logic [3:0]  mp_ff, mp_in;
   logic [2:0]  amp_ff, amp_in;
   logic [7:0]  quote_ff, quote_in;
   logic [31:0] vstart_ff, vstart_in;
   logic [31:0] vlen_ff, vlen_in;
   logic [6:0]  count_ff, count_in;

   logic [7:0]  c;
   logic        is_gt;
   logic [3:0]  open_next;
   logic [2:0]  attr_next;
   logic [3:0]  close_next;
   logic [31:0] off_inc;
   logic [31:0] diff_val;
   logic [31:0] diff_close;
   logic [31:0] tail_len;
   logic        rep;
   logic        bts;
   logic        tail_rep;
   logic        span_v;
   logic [1:0]  rep_kind;
   logic [31:0] rep_start;
   logic [31:0] rep_len;
   logic [6:0]  count_after;
   rsp_type     span_item;
   rsp_type     done_item;

   // Matchers and offset arithmetic.
   assign c          = fold(doc_byte);
   assign is_gt      = (doc_byte == CH_GT);
   assign open_next  = adv_open(mp_ff, c);
   assign attr_next  = adv_attr(amp_ff, c);
   assign close_next = adv_close(mp_ff, c);
   assign off_inc    = offset_ff + 32'd1;
   assign diff_val   = offset_ff - vstart_ff;
   assign diff_close = offset_ff - 32'd8 - vstart_ff;

   // Mode transitions for one byte.
   always_comb begin
      mode_in   = mode_ff;
      mp_in     = mp_ff;
      amp_in    = amp_ff;
      quote_in  = quote_ff;
      vstart_in = vstart_ff;
      vlen_in   = vlen_ff;
      rep       = 1'b0;
      bts       = 1'b0;
      rep_kind  = KIND_SRC;
      rep_start = vstart_ff;
      rep_len   = vlen_ff;
      case (mode_ff)
         M_SEARCH: begin
            if (open_next == OPEN_LEN) begin
               mode_in = M_TAG;
               mp_in   = 4'd0;
               amp_in  = 3'd0;
            end else begin
               mp_in = open_next;
            end
         end
         M_TAG: begin
            if (is_gt) begin
               mode_in   = M_BODY;
               vstart_in = off_inc;
               mp_in     = 4'd0;
            end else if (attr_next == ATTR_LEN) begin
               amp_in  = 3'd0;
               mode_in = M_AFTER_SRC;
            end else begin
               amp_in = attr_next;
            end
         end
         M_AFTER_SRC: begin
            if (is_gt) begin
               bts = 1'b1;
            end else if (doc_byte == CH_DQUOTE || doc_byte == CH_SQUOTE) begin
               quote_in  = doc_byte;
               vstart_in = off_inc;
               mode_in   = M_VALUE;
            end else begin
               vlen_in = 32'd0;
               mode_in = M_TAG_REST;
            end
         end
         M_VALUE: begin
            if (is_gt) begin
               vlen_in = diff_val;
               if (diff_val != 32'd0) begin
                  rep     = 1'b1;
                  rep_len = diff_val;
               end else begin
                  bts = 1'b1;
               end
            end else if (doc_byte == quote_ff) begin
               vlen_in = diff_val;
               mode_in = M_TAG_REST;
            end
         end
         M_TAG_REST: begin
            if (is_gt) begin
               if (vlen_ff != 32'd0) begin
                  rep = 1'b1;
               end else begin
                  bts = 1'b1;
               end
            end
         end
         M_BODY: begin
            if (close_next == CLOSE_LEN) begin
               if (diff_close != 32'd0) begin
                  rep      = 1'b1;
                  rep_kind = KIND_BODY;
                  rep_len  = diff_close;
               end else begin
                  bts = 1'b1;
               end
            end else begin
               mp_in = close_next;
            end
         end
         default: begin
         end
      endcase

      // A report or a closed tag returns to searching, or stops at the limit.
      count_after = rep ? (count_ff + 7'd1) : count_ff;
      if (rep || bts) begin
         mode_in = (count_after >= MAX_COUNT) ? M_STOPPED : M_SEARCH;
         mp_in   = 4'd0;
         amp_in  = 3'd0;
      end
   end

   // An open body at the end of the document is reported as well.
   assign tail_len = off_inc - vstart_in;
   assign tail_rep = doc_end && (mode_in == M_BODY) && (tail_len != 32'd0);
   assign span_v   = rep || tail_rep;

   // Result assembly.
   always_comb begin
      span_item.span_kind     = rep ? rep_kind : KIND_BODY;
      span_item.span_start    = rep ? rep_start : vstart_in;
      span_item.span_length   = rep ? rep_len : tail_len;
      span_item.scripts_found = count_ff + 7'd1;
      span_item.final_of_item = !doc_end;

      done_item.span_kind     = KIND_DONE;
      done_item.span_start    = 32'd0;
      done_item.span_length   = 32'd0;
      done_item.scripts_found = span_v ? (count_ff + 7'd1) : count_ff;
      done_item.final_of_item = 1'b1;

      push.count = advance ? (2'(span_v) + 2'(doc_end)) : 2'd0;
      push.item0 = span_v ? span_item : done_item;
      push.item1 = done_item;
   end

   // Next state; the last byte of a document starts over.
   always_comb begin
      offset_in = off_inc;
      count_in  = count_after;
      if (tail_rep) begin
         count_in = count_ff + 7'd1;
      end
      if (doc_end) begin
         offset_in = 32'd0;
         count_in  = 7'd0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 32'd0;
         mode_ff   <= M_SEARCH;
         mp_ff     <= 4'd0;
         amp_ff    <= 3'd0;
         count_ff  <= 7'd0;
      end else if (advance) begin
         offset_ff <= offset_in;
         count_ff  <= count_in;
         if (doc_end) begin
            mode_ff <= M_SEARCH;
            mp_ff   <= 4'd0;
            amp_ff  <= 3'd0;
         end else begin
            mode_ff <= mode_in;
            mp_ff   <= mp_in;
            amp_ff  <= amp_in;
         end
      end
   end

   // Value registers need no reset: each is written before it is read.
   always_ff @(posedge clock) begin
      if (advance) begin
         quote_ff  <= quote_in;
         vstart_ff <= vstart_in;
         vlen_ff   <= vlen_in;
      end
   end

   // The report count never passes the limit.
   a_count_limit : assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("report count above limit");

   // Two results from one request are always a span followed by the done item.
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.item0.span_kind != KIND_DONE
                          && push.item1.span_kind == KIND_DONE)
      else $error("bad result pair");

   // Once stopped, scanning stays stopped until the document ends.
   a_stopped_holds : assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_STOPPED && !(advance && doc_end) |=> mode_ff == M_STOPPED)
      else $error("left stopped mode early");

endmodule

/* rtl/hsse_rsp_fifo.sv */
// Four-entry result queue that takes up to two results a cycle and gives one.
`timescale 1ns / 1ps

module hsse_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  hsse_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hsse_pkg::rsp_type  rsp_item
);
   import hsse_pkg::*;

   localparam int DEPTH = 4;

   rsp_type     mem_ff [DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;

   // Space for a full pair keeps the scanner from ever overrunning the queue.
   assign room      = (count_ff <= 3'(DEPTH - 2));
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Pointer and fill arithmetic.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(push.count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage writes.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.item1;
      end
   end

   // A push never exceeds the free space.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> (4'(count_ff) + 4'(push.count)) <= 4'(DEPTH))
      else $error("result queue overflow");

   // Fill level stays within the depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(DEPTH))
      else $error("result queue count out of range");

   // With no push and no pop, the fill level holds.
   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd0 && !pop |=> $stable(count_ff))
      else $error("result queue count changed while idle");

endmodule

/* rtl/html_script_span_extractor_top.sv */
// Top level of the script span extractor: input register, scanner and result queue.
`timescale 1ns / 1ps

// The block takes one document byte per cycle and reports, for each <script> tag, either
// the span of its quoted src value (kind 0) or the span of its inline body (kind 1); on the
// byte flagged as the document's last it adds a done item (kind 2) carrying the number of
// spans reported, then starts over at offset zero for the next document. A request is held
// in an input register while the scanner steps on it, and its results are registered into
// a four-entry queue before the first is visible. Sustained rate is one request per cycle
// while the queue has room; the queue takes the second result that a final byte can add,
// and req_ready drops only when the queue holds more than two results. Reporting stops
// after MAX_SCRIPTS spans until the end of the document.

module html_script_span_extractor_top #(
   parameter int MAX_SCRIPTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_doc_byte,
   input  logic        req_doc_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_span_kind,
   output logic [31:0] rsp_span_start,
   output logic [31:0] rsp_span_length,
   output logic [6:0]  rsp_scripts_found,
   output logic        rsp_final_of_item
);
   import hsse_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       room;
   logic       advance;
   push_type   push;
   rsp_type    rsp_item;

   // The held request moves on when the queue has room for a full pair.
   assign advance     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || room;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Request payload register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_doc_byte;
         in_end_ff  <= req_doc_end;
      end
   end

   hsse_scan #(
      .MAX_SCRIPTS(MAX_SCRIPTS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .doc_byte (in_byte_ff),
      .doc_end  (in_end_ff),
      .push     (push)
   );

   hsse_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Result fields.
   assign rsp_span_kind     = rsp_item.span_kind;
   assign rsp_span_start    = rsp_item.span_start;
   assign rsp_span_length   = rsp_item.span_length;
   assign rsp_scripts_found = rsp_item.scripts_found;
   assign rsp_final_of_item = rsp_item.final_of_item;

endmodule
